>>> src/qte_pkg.sv
// qte_pkg: widths, constants and the cordic angle table of the quaternion to euler core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;

  localparam int QW   = 16;  // quaternion component width
  localparam int PW   = 32;  // product width
  localparam int TW   = 34;  // trig operand width, units of 2^-30
  localparam int T2W  = 32;  // clamped pitch term width
  localparam int SQW  = 61;  // radicand width
  localparam int RW   = 31;  // square root width
  localparam int XW   = 36;  // cordic vector width
  localparam int ZW   = 28;  // cordic angle accumulator width, units of 2^-24 rad
  localparam int AW   = 16;  // angle output width
  localparam int PAW  = 15;  // pitch output width
  localparam int MAX_STEPS = 24;

  localparam logic signed [TW-1:0] ONE_Q30     = TW'(64'sd1073741824);
  localparam logic signed [ZW-1:0] HALF_PI_Q24 = ZW'(32'sd26353589);
  localparam logic signed [16:0]   PI_Q13      = 17'sd25736;
  localparam logic signed [16:0]   HALF_PI_Q13 = 17'sd12868;
  localparam logic [SQW-1:0]       ONE_Q60     = SQW'(1) << 60;

  localparam logic signed [ZW-1:0] ATAN_TAB [MAX_STEPS] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
    28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768, 28'sd16384,
    28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024, 28'sd512, 28'sd256, 28'sd128,
    28'sd64, 28'sd32, 28'sd16, 28'sd8, 28'sd4, 28'sd2
  };

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage
`default_nettype wire

>>> src/qte_if.sv
// qte_quat_if and qte_euler_if: valid/ready channels of the core
// depends on qte_pkg
`timescale 1ns / 1ps
`default_nettype none
interface qte_quat_if;
  import qte_pkg::*;
  logic valid;
  logic ready;
  logic signed [QW-1:0] quat_w;
  logic signed [QW-1:0] quat_x;
  logic signed [QW-1:0] quat_y;
  logic signed [QW-1:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if;
  import qte_pkg::*;
  logic valid;
  logic ready;
  logic signed [AW-1:0]  yaw_angle;
  logic signed [PAW-1:0] pitch_angle;
  logic signed [AW-1:0]  roll_angle;
  modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
  modport sink (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface
`default_nettype wire

>>> src/qte_front.sv
// qte_front: products, trig terms and pitch square, three register stages
// depends on qte_pkg
`timescale 1ns / 1ps
`default_nettype none
module qte_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  qte_pkg::pipe_ctl_t           ctl_i,
  input  wire signed [qte_pkg::QW-1:0] w_i,
  input  wire signed [qte_pkg::QW-1:0] x_i,
  input  wire signed [qte_pkg::QW-1:0] y_i,
  input  wire signed [qte_pkg::QW-1:0] z_i,
  output logic                         valid_o,
  output logic signed [qte_pkg::TW-1:0]  t0_o,
  output logic signed [qte_pkg::TW-1:0]  t1_o,
  output logic signed [qte_pkg::T2W-1:0] t2_o,
  output logic signed [qte_pkg::TW-1:0]  t3_o,
  output logic signed [qte_pkg::TW-1:0]  t4_o,
  output logic [qte_pkg::SQW-1:0]      sq_o
);
  import qte_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic signed [PW-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;
  logic signed [TW-1:0] t0_q, t1_q, t3_q, t4_q, t0_d, t1_d, t3_d, t4_d, t2r;
  logic signed [T2W-1:0] t2_q, t2_d;
  logic [RW-1:0] a2;
  logic [2*RW-1:0] sq_full;

  always_comb begin
    t0_d = (TW'(wx_q) + TW'(yz_q)) <<< 1;
    t1_d = ONE_Q30 - ((TW'(xx_q) + TW'(yy_q)) <<< 1);
    t3_d = (TW'(wz_q) + TW'(xy_q)) <<< 1;
    t4_d = ONE_Q30 - ((TW'(yy_q) + TW'(zz_q)) <<< 1);
    t2r  = (TW'(wy_q) - TW'(zx_q)) <<< 1;
    if (t2r > ONE_Q30) begin
      t2_d = T2W'(ONE_Q30);
    end else if (t2r < -ONE_Q30) begin
      t2_d = T2W'(-ONE_Q30);
    end else begin
      t2_d = T2W'(t2r);
    end
  end

  assign a2      = t2_q[T2W-1] ? RW'(-t2_q) : RW'(t2_q);
  assign sq_full = a2 * a2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (ctl_i.en) begin
      v1_q <= ctl_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      wx_q <= w_i * x_i;
      yz_q <= y_i * z_i;
      xx_q <= x_i * x_i;
      yy_q <= y_i * y_i;
      wy_q <= w_i * y_i;
      zx_q <= z_i * x_i;
      wz_q <= w_i * z_i;
      xy_q <= x_i * y_i;
      zz_q <= z_i * z_i;
      t0_q <= t0_d;
      t1_q <= t1_d;
      t2_q <= t2_d;
      t3_q <= t3_d;
      t4_q <= t4_d;
      t0_o <= t0_q;
      t1_o <= t1_q;
      t2_o <= t2_q;
      t3_o <= t3_q;
      t4_o <= t4_q;
      sq_o <= SQW'(sq_full);
    end
  end

  assign valid_o = v3_q;

endmodule
`default_nettype wire

>>> src/qte_isqrt.sv
// qte_isqrt: pipelined floor square root of one minus the pitch square, one bit per stage
// depends on qte_pkg
`timescale 1ns / 1ps
`default_nettype none
module qte_isqrt (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  qte_pkg::pipe_ctl_t       ctl_i,
  input  wire [qte_pkg::SQW-1:0]   sq_i,
  output logic                     valid_o,
  output logic [qte_pkg::RW-1:0]   root_o
);
  import qte_pkg::*;

  localparam int EW = 2 * RW;

  logic [SQW-1:0] rem_q [RW];
  logic [RW-1:0]  root_q [RW];
  logic           v_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [SQW-1:0] rem_c;
    logic [RW-1:0]  root_c;
    logic           v_c;
    logic [EW-1:0]  trial;
    if (k == 0) begin : g_first
      assign rem_c  = ONE_Q60 - sq_i;
      assign root_c = '0;
      assign v_c    = ctl_i.valid;
    end else begin : g_next
      assign rem_c  = rem_q[k-1];
      assign root_c = root_q[k-1];
      assign v_c    = v_q[k-1];
    end
    assign trial = (EW'(root_c) << (B + 1)) + (EW'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (ctl_i.en) begin
        v_q[k] <= v_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        if (EW'(rem_c) >= trial) begin
          rem_q[k]  <= SQW'(EW'(rem_c) - trial);
          root_q[k] <= root_c | (RW'(1) << B);
        end else begin
          rem_q[k]  <= rem_c;
          root_q[k] <= root_c;
        end
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = root_q[RW-1];

endmodule
`default_nettype wire

>>> src/qte_cordic.sv
// qte_cordic: pipelined vectoring cordic atan2 with quadrant pre-rotation, q3.13 result
// depends on qte_pkg
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic #(
  parameter int STEPS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  qte_pkg::pipe_ctl_t           ctl_i,
  input  wire signed [qte_pkg::XW-1:0] y_i,
  input  wire signed [qte_pkg::XW-1:0] x_i,
  output logic                         valid_o,
  output logic signed [qte_pkg::AW-1:0] angle_o
);
  import qte_pkg::*;

  localparam int N = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;

  logic signed [XW-1:0] x_q [N+1];
  logic signed [XW-1:0] y_q [N+1];
  logic signed [ZW-1:0] z_q [N+1];
  logic                 zf_q [N+1];
  logic                 v_q [N+1];
  logic                 vo_q;

  logic signed [XW-1:0] xp, yp;
  logic signed [ZW-1:0] zp, zr;
  logic signed [16:0]   r;

  always_comb begin
    xp = x_i;
    yp = y_i;
    zp = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        xp = y_i;
        yp = -x_i;
        zp = HALF_PI_Q24;
      end else begin
        xp = -y_i;
        yp = x_i;
        zp = -HALF_PI_Q24;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
      vo_q   <= 1'b0;
    end else if (ctl_i.en) begin
      v_q[0] <= ctl_i.valid;
      vo_q   <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      x_q[0]  <= xp;
      y_q[0]  <= yp;
      z_q[0]  <= zp;
      zf_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (ctl_i.en) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        zf_q[i+1] <= zf_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN_TAB[i];
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN_TAB[i];
        end
      end
    end
  end

  assign zr = z_q[N] + ZW'(1024);
  assign r  = 17'(zr >>> 11);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      if (zf_q[N]) begin
        angle_o <= '0;
      end else if (r > PI_Q13) begin
        angle_o <= AW'(PI_Q13);
      end else if (r < -PI_Q13) begin
        angle_o <= AW'(-PI_Q13);
      end else begin
        angle_o <= AW'(r);
      end
    end
  end

  assign valid_o = vo_q;

endmodule
`default_nettype wire

>>> src/quaternion_to_euler_core.sv
// quaternion_to_euler_core: quaternion to yaw and roll in q3.13 radians and pitch in q2.13 radians
// the pipeline runs through the front end, the 31-stage square root and the cordic stages;
// throughput: one transaction per cycle unless a finished result waits to be taken
// the whole pipeline holds while a finished result waits to be taken
// reset clears all valid bits asynchronously; payload registers are not reset
// depends on qte_pkg, qte_if, qte_front, qte_isqrt, qte_cordic
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  qte_quat_if.sink     quat_i,
  qte_euler_if.source  euler_o
);
  import qte_pkg::*;

  localparam int DW = 4 * TW + T2W;

  logic      adv;
  pipe_ctl_t in_ctl, mid_ctl, cor_ctl;
  logic      fr_v, sq_v, rv, pv, yv;
  logic signed [TW-1:0]  t0, t1, t3, t4, d0, d1, d3, d4;
  logic signed [T2W-1:0] t2, d2;
  logic [SQW-1:0] sq;
  logic [RW-1:0]  root;
  logic [DW-1:0]  dl_q [RW];
  logic signed [AW-1:0] roll_a, pitch_a, yaw_a;
  logic signed [16:0]   pitch_x;

  logic                  out_v_q;
  logic signed [AW-1:0]  yaw_q, roll_q;
  logic signed [PAW-1:0] pitch_q;

  assign adv          = !out_v_q || euler_o.ready;
  assign quat_i.ready = adv;
  assign in_ctl       = '{en: adv, valid: quat_i.valid};

  qte_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (in_ctl),
    .w_i     (quat_i.quat_w),
    .x_i     (quat_i.quat_z),
    .y_i     (quat_i.quat_y),
    .z_i     (quat_i.quat_x),
    .valid_o (fr_v),
    .t0_o    (t0),
    .t1_o    (t1),
    .t2_o    (t2),
    .t3_o    (t3),
    .t4_o    (t4),
    .sq_o    (sq)
  );

  assign mid_ctl = '{en: adv, valid: fr_v};

  qte_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mid_ctl),
    .sq_i    (sq),
    .valid_o (sq_v),
    .root_o  (root)
  );

  // trig terms wait alongside the square root
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl_q[0] <= {t0, t1, t3, t4, t2};
      for (int k = 1; k < RW; k++) begin
        dl_q[k] <= dl_q[k-1];
      end
    end
  end

  assign {d0, d1, d3, d4, d2} = dl_q[RW-1];

  assign cor_ctl = '{en: adv, valid: sq_v};

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (cor_ctl),
    .y_i     (XW'(d0)),
    .x_i     (XW'(d1)),
    .valid_o (rv),
    .angle_o (roll_a)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (cor_ctl),
    .y_i     (XW'(d2)),
    .x_i     (XW'({1'b0, root})),
    .valid_o (pv),
    .angle_o (pitch_a)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (cor_ctl),
    .y_i     (XW'(d3)),
    .x_i     (XW'(d4)),
    .valid_o (yv),
    .angle_o (yaw_a)
  );

  assign pitch_x = 17'(pitch_a);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= pv && rv && yv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      yaw_q  <= yaw_a;
      roll_q <= roll_a;
      if (pitch_x > HALF_PI_Q13) begin
        pitch_q <= PAW'(HALF_PI_Q13);
      end else if (pitch_x < -HALF_PI_Q13) begin
        pitch_q <= PAW'(-HALF_PI_Q13);
      end else begin
        pitch_q <= PAW'(pitch_x);
      end
    end
  end

  assign euler_o.valid       = out_v_q;
  assign euler_o.yaw_angle   = yaw_q;
  assign euler_o.pitch_angle = pitch_q;
  assign euler_o.roll_angle  = roll_q;

  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pv == rv) && (pv == yv))
    else $error("cordic lanes out of step");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> quat_i.ready)
    else $error("input stalled with empty output");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (17'(pitch_q) <= HALF_PI_Q13) && (17'(pitch_q) >= -HALF_PI_Q13))
    else $error("pitch out of range");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !euler_o.ready) |=> out_v_q && $stable(yaw_q) && $stable(roll_q))
    else $error("result lost while stalled");

endmodule
`default_nettype wire

>>> verif/quaternion_to_euler_checker.sv
// quaternion_to_euler_checker: watches both channels of the core, predicts the euler angles
// of every accepted quaternion and compares them in order; depends on qte_pkg and qte_if
`timescale 1ns / 1ps
module quaternion_to_euler_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  qte_quat_if        quat_mon,
  qte_euler_if       euler_mon,
  output int         fail_count_o,
  output int         pending_o,
  output int         seen_count_o
);
  import qte_pkg::*;

  typedef struct packed {
    logic signed [AW-1:0]  yaw;
    logic signed [PAW-1:0] pitch;
    logic signed [AW-1:0]  roll;
  } euler_t;

  euler_t angle_queue[$];

  function automatic longint shr_arith(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clip(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z;
    longint t;
    longint dx;
    longint dy;
    int steps;
    z = 0;
    if (x == 0 && y == 0) return 0;
    steps = CORDIC_STEPS > MAX_STEPS ? MAX_STEPS : CORDIC_STEPS;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALF_PI_Q24;
      end else begin
        x = -y; y = t; z = -HALF_PI_Q24;
      end
    end
    for (int i = 0; i < steps; i++) begin
      dx = shr_arith(y, i);
      dy = shr_arith(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end
    end
    return clip(shr_arith(z + 1024, 11), PI_Q13);
  endfunction

  function automatic euler_t predict_angles(logic signed [QW-1:0] qw, logic signed [QW-1:0] qx,
                                            logic signed [QW-1:0] qy, logic signed [QW-1:0] qz);
    longint w, xa, ya, za, t0, t1, t2, t3, t4, c, one;
    euler_t e;
    one = longint'(1) << 30;
    w = qw; za = qx; ya = qy; xa = qz;
    t0 = 2 * (w * xa + ya * za);
    t1 = one - 2 * (xa * xa + ya * ya);
    t2 = 2 * (w * ya - za * xa);
    if (t2 > one) t2 = one;
    if (t2 < -one) t2 = -one;
    c = int_sqrt((longint'(1) << 60) - t2 * t2);
    t3 = 2 * (w * za + xa * ya);
    t4 = one - 2 * (ya * ya + za * za);
    e.roll = AW'(vector_angle(t0, t1));
    e.pitch = PAW'(clip(vector_angle(t2, c), HALF_PI_Q13));
    e.yaw = AW'(vector_angle(t3, t4));
    return e;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    seen_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    euler_t e;
    if (rst_ni) begin
      if (quat_mon.valid && quat_mon.ready)
        angle_queue.push_back(predict_angles(quat_mon.quat_w, quat_mon.quat_x,
                                             quat_mon.quat_y, quat_mon.quat_z));
      if (euler_mon.valid && euler_mon.ready) begin
        seen_count_o++;
        if (angle_queue.size() == 0) begin
          $display("unexpected transaction at %0t", $time);
          fail_count_o++;
        end else begin
          e = angle_queue.pop_front();
          if (euler_mon.yaw_angle !== e.yaw) report("yaw", euler_mon.yaw_angle, e.yaw);
          if (euler_mon.pitch_angle !== e.pitch)
            report("pitch", euler_mon.pitch_angle, e.pitch);
          if (euler_mon.roll_angle !== e.roll) report("roll", euler_mon.roll_angle, e.roll);
        end
      end
    end
    pending_o = angle_queue.size();
  end
endmodule

>>> verif/quaternion_to_euler_core_test.sv
// quaternion_to_euler_core_test: drives quaternions with random gaps and stalls into the core
// and gives the verdict; depends on qte_pkg, qte_if, the core and quaternion_to_euler_checker
`timescale 1ns / 1ps
module quaternion_to_euler_core_test;
  import qte_pkg::*;

  localparam int LATENCY = 16 + 37;
  localparam int RANDOM_ITEMS = 830;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int fail_count;
  int pending;
  int seen_count;
  longint cycle_count = 0;
  int sent_count = 0;

  qte_quat_if quat_ch ();
  qte_euler_if euler_ch ();

  quaternion_to_euler_core #(.CORDIC_STEPS(16)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .quat_i(quat_ch), .euler_o(euler_ch)
  );

  quaternion_to_euler_checker #(.CORDIC_STEPS(16)) checker_inst (
    .clk_i(clk_i), .rst_ni(rst_ni), .quat_mon(quat_ch), .euler_mon(euler_ch),
    .fail_count_o(fail_count), .pending_o(pending), .seen_count_o(seen_count)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result stalls
  initial begin
    int g;
    euler_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      euler_ch.ready = 1'b1;
      if (sent_count > 200 && sent_count < 300) continue;
      @(posedge clk_i);
      g = gap_length();
      if (g > 0) begin
        @(negedge clk_i);
        euler_ch.ready = 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end
    end
  end

  task automatic send_quat(logic [QW-1:0] w, logic [QW-1:0] x, logic [QW-1:0] y,
                           logic [QW-1:0] z, bit gaps);
    int g;
    g = gaps ? gap_length() : 0;
    if (g > 0) begin
      quat_ch.valid = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    quat_ch.valid = 1'b1;
    quat_ch.quat_w = w;
    quat_ch.quat_x = x;
    quat_ch.quat_y = y;
    quat_ch.quat_z = z;
    do @(posedge clk_i); while (!quat_ch.ready);
    sent_count++;
    @(negedge clk_i);
    quat_ch.valid = 1'b0;
  endtask

  function automatic logic [QW-1:0] unit_part(real v);
    return QW'($rtoi(v * 32767.0));
  endfunction

  task automatic send_unit(bit gaps);
    real a, b, c, d, n;
    a = $itor($signed($urandom_range(0, 2000)) - 1000);
    b = $itor($signed($urandom_range(0, 2000)) - 1000);
    c = $itor($signed($urandom_range(0, 2000)) - 1000);
    d = $itor($signed($urandom_range(0, 2000)) - 1000);
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n == 0.0) begin a = 1.0; n = 1.0; end
    send_quat(unit_part(a / n), unit_part(b / n), unit_part(c / n), unit_part(d / n), gaps);
  endtask

  initial begin
    int waited;
    quat_ch.valid = 1'b0;
    quat_ch.quat_w = '0;
    quat_ch.quat_x = '0;
    quat_ch.quat_y = '0;
    quat_ch.quat_z = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed corners: identity, axes, gimbal lock, zero vector, extremes
    send_quat(16'sd32767, 0, 0, 0, 0);
    send_quat(16'sh8000, 0, 0, 0, 0);
    send_quat(0, 16'sd32767, 0, 0, 0);
    send_quat(0, 0, 16'sd32767, 0, 0);
    send_quat(0, 0, 0, 16'sd32767, 0);
    send_quat(0, 0, 0, 0, 0);
    send_quat(16'sd23170, 0, 16'sd23170, 0, 0);
    send_quat(16'sd23170, 0, 16'sh8000 + 16'sd9598, 0, 0);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 0);
    send_quat(16'sd32767, 16'sh8000, 16'sd32767, 16'sh8000, 0);
    send_quat(16'sh8000, 16'sd32767, 16'sh8000, 16'sd32767, 0);
    send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff, 0);
    send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 0);
    send_quat(0, 16'sd23170, 0, 16'sd23170, 0);
    send_quat(0, 16'sh8000, 0, 0, 0);
    send_quat(0, 0, 0, 16'sh8000, 1);
    send_quat(16'sd1, 16'sd2, 16'sd4, 16'sd8, 1);
    send_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 1);
    send_quat(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 400) begin
        waited = 0;
        while (pending != 0 && waited < 100000) begin
          @(negedge clk_i);
          waited++;
        end
      end
      if ($urandom_range(0, 3) != 0) send_unit(1);
      else send_quat($urandom, $urandom, $urandom, $urandom, 1);
    end

    waited = 0;
    while (pending != 0 && waited < 200000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (LATENCY + 10) @(negedge clk_i);
    $display("sent %0d quaternions (corners, unit and raw random), %0d angle sets checked",
             sent_count, seen_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

>>> filelist.f
src/qte_pkg.sv
src/qte_if.sv
src/qte_front.sv
src/qte_isqrt.sv
src/qte_cordic.sv
src/quaternion_to_euler_core.sv
verif/quaternion_to_euler_checker.sv
verif/quaternion_to_euler_core_test.sv
